// ----- sv/irct_pkg.sv -----
// ----------------------------------------------------------------------------
// irct_pkg: shared types and constants for the IRC message tokenizer
// Character codes, field kinds and the packed result word layout.
// ----------------------------------------------------------------------------
package irct_pkg;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;
	localparam int IDX_W   = 4;
	localparam int ARG_W   = 5;
	localparam int PHASE_W = 3;
	localparam int OUT_W   = 24;

	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

	localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PREFIX   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_COMMAND  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MIDDLE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRAILING = 3'd4;

	typedef struct packed {
		logic [ARG_W-1:0]  arg_total;
		logic              had_prefix;
		logic              nick_split;
		logic              field_start;
		logic [IDX_W-1:0]  arg_index;
		logic [KIND_W-1:0] field_kind;
		logic [BYTE_W-1:0] out_byte;
	} res_t;

	typedef struct packed {
		res_t res;
		logic last;
	} word_t;

endpackage

// ----- sv/irc_message_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// irc_message_tokenizer_top: IRC message line tokenizer
// Tags each byte of a line as separator, prefix, command or argument.
// Each result is registered in the result register, or in the skid register while the result register is held.
// Throughput: one byte per cycle while the skid register is empty; the parse state updates at the input accept.
// A two-entry output (result register plus skid register) keeps input
// ready while one result waits to be taken.
// Reset: arst_n clears the parse state and the valid flags of both output entries at once.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_top
	import irct_pkg::*;
#(
	parameter int MSG_LEN  = 512,
	parameter int MAX_ARGS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              s_tlast,   // end_of_line
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [7:0] out_byte, [10:8] field_kind,
	                                     // [14:11] arg_index, [15] field_start,
	                                     // [16] nick_split, [17] had_prefix,
	                                     // [22:18] arg_total, [23] zero
	output logic              m_tlast    // last_result
);

	localparam int POS_W = (MSG_LEN > 2) ? $clog2(MSG_LEN) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MSG_LEN - 1);
	localparam logic [ARG_W-1:0] ARG_LIMIT = ARG_W'(MAX_ARGS);

	localparam logic [PHASE_W-1:0] PH_START   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_PREFIX  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_GAP_CMD = 3'd2;
	localparam logic [PHASE_W-1:0] PH_COMMAND = 3'd3;
	localparam logic [PHASE_W-1:0] PH_GAP_ARG = 3'd4;
	localparam logic [PHASE_W-1:0] PH_MIDDLE  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_TAIL    = 3'd6;
	localparam logic [PHASE_W-1:0] PH_DROP    = 3'd7;

	logic [POS_W-1:0]   pos_q;
	logic [PHASE_W-1:0] phase_q;
	logic [ARG_W-1:0]   argc_q;
	logic               prefix_q, split_q, ended_q, pending_q, trailing_q;

	logic [POS_W-1:0]   pos_c;
	logic [PHASE_W-1:0] phase_c, phase_n;
	logic [ARG_W-1:0]   argc_c, argc_n;
	logic               prefix_c, split_c, pending_c, trailing_c;
	logic               prefix_n, split_n, pending_n, trailing_n;
	logic [IDX_W-1:0]   cur;
	logic [BYTE_W-1:0]  b;
	res_t               res;

	word_t out_q, skid_q, new_w;
	logic  out_valid_q, skid_valid_q;
	logic  accept, pop;

	assign b      = s_tdata;
	assign accept = s_tvalid && s_tready;
	assign pop    = out_valid_q && m_tready;

	// line state after an end of line reads as cleared
	always_comb begin
		pos_c      = ended_q ? '0 : pos_q;
		phase_c    = ended_q ? PH_START : phase_q;
		argc_c     = ended_q ? '0 : argc_q;
		prefix_c   = ended_q ? 1'b0 : prefix_q;
		split_c    = ended_q ? 1'b0 : split_q;
		pending_c  = ended_q ? 1'b0 : pending_q;
		trailing_c = ended_q ? 1'b0 : trailing_q;
	end

	always_comb begin
		phase_n    = phase_c;
		argc_n     = argc_c;
		prefix_n   = prefix_c;
		split_n    = split_c;
		pending_n  = pending_c;
		trailing_n = trailing_c;
		res        = '0;
		cur        = (argc_c != '0) ? IDX_W'(argc_c - 1'b1) : '0;

		if (pos_c >= POS_LAST || b == CH_NUL) begin
			phase_n = PH_DROP;
		end

		unique case (phase_n)
			PH_START: begin
				if (b == CH_COLON) begin
					prefix_n  = 1'b1;
					pending_n = 1'b1;
					phase_n   = PH_PREFIX;
				end else if (b == CH_SPACE) begin
					phase_n = PH_GAP_ARG;
				end else begin
					res.field_kind  = KIND_COMMAND;
					res.field_start = 1'b1;
					phase_n         = PH_COMMAND;
				end
			end
			PH_PREFIX: begin
				if (b == CH_SPACE) begin
					pending_n = 1'b0;
					phase_n   = PH_GAP_CMD;
				end else begin
					res.field_kind  = KIND_PREFIX;
					res.field_start = pending_c;
					pending_n       = 1'b0;
					if (b == CH_BANG && !split_c) begin
						res.nick_split = 1'b1;
						split_n        = 1'b1;
					end
				end
			end
			PH_GAP_CMD: begin
				if (b != CH_SPACE) begin
					res.field_kind  = KIND_COMMAND;
					res.field_start = 1'b1;
					phase_n         = PH_COMMAND;
				end
			end
			PH_COMMAND: begin
				if (b == CH_SPACE) begin
					phase_n = PH_GAP_ARG;
				end else begin
					res.field_kind = KIND_COMMAND;
				end
			end
			PH_GAP_ARG: begin
				if (b != CH_SPACE) begin
					argc_n = argc_c + 1'b1;
					if (b == CH_COLON) begin
						pending_n  = 1'b1;
						trailing_n = 1'b1;
						phase_n    = PH_TAIL;
					end else begin
						res.field_kind  = KIND_MIDDLE;
						res.arg_index   = argc_c[IDX_W-1:0];
						res.field_start = 1'b1;
						if (argc_n >= ARG_LIMIT) begin
							trailing_n = 1'b0;
							phase_n    = PH_TAIL;
						end else begin
							phase_n = PH_MIDDLE;
						end
					end
				end
			end
			PH_MIDDLE: begin
				if (b == CH_SPACE) begin
					phase_n = PH_GAP_ARG;
				end else begin
					res.field_kind = KIND_MIDDLE;
					res.arg_index  = cur;
				end
			end
			PH_TAIL: begin
				res.field_kind  = trailing_c ? KIND_TRAILING : KIND_MIDDLE;
				res.arg_index   = cur;
				res.field_start = pending_c;
				pending_n       = 1'b0;
			end
			default: begin
			end
		endcase

		res.out_byte   = b;
		res.had_prefix = prefix_n;
		res.arg_total  = argc_n;
	end

	assign new_w.res  = res;
	assign new_w.last = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= PH_START;
			argc_q     <= '0;
			prefix_q   <= 1'b0;
			split_q    <= 1'b0;
			ended_q    <= 1'b0;
			pending_q  <= 1'b0;
			trailing_q <= 1'b0;
		end else if (accept) begin
			pos_q      <= (pos_c < POS_LAST) ? pos_c + 1'b1 : pos_c;
			phase_q    <= phase_n;
			argc_q     <= argc_n;
			prefix_q   <= prefix_n;
			split_q    <= split_n;
			ended_q    <= s_tlast;
			pending_q  <= pending_n;
			trailing_q <= trailing_n;
		end
	end

	// result register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : new_w;
		end else if (accept) begin
			skid_q <= new_w;
		end
	end

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.res};
	assign m_tlast  = out_q.last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty result register");

	a_split_in_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.res.nick_split) |-> out_q.res.field_kind == KIND_PREFIX)
		else $error("nick split outside prefix");

	a_index_only_args: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.res.arg_index != '0) |->
		(out_q.res.field_kind == KIND_MIDDLE || out_q.res.field_kind == KIND_TRAILING))
		else $error("argument index on non-argument byte");

	a_start_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.res.field_start) |-> out_q.res.field_kind != KIND_NONE)
		else $error("field start on dropped byte");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> ended_q)
		else $error("end of line not recorded");

endmodule

// ----- bench/tb_irc_message_tokenizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_irc_message_tokenizer_top: self-checking bench for the IRC line tokenizer
// Feeds directed lines, then random well-formed, broken and noise lines,
// tags every byte in a built-in line parser and checks each output word
// against it in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_irc_message_tokenizer_top;
	import irct_pkg::*;

	localparam int MSG_LEN     = 512;
	localparam int MAX_ARGS    = 15;
	localparam int ITEMS       = 1950;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;

	typedef enum logic [2:0] {
		AT_LINE_START, IN_PREFIX, BEFORE_CMD, IN_CMD,
		BEFORE_ARG, IN_ARG, IN_REST, DISCARD
	} line_phase_t;

	class tag_board;
		word_t       tags_due[$];
		int          errors, shown, words_in, words_out, top_args;
		int          kind_hits[8];
		int unsigned pos, n_args;
		line_phase_t phase;
		bit          saw_prefix, saw_bang, eol_seen, open_pending, rest_is_trailing;

		function new();
			errors = 0;
			shown = 0;
			words_in = 0;
			words_out = 0;
			top_args = 0;
			foreach (kind_hits[i]) kind_hits[i] = 0;
			clear_line();
		endfunction

		function void clear_line();
			pos = 0;
			phase = AT_LINE_START;
			n_args = 0;
			saw_prefix = 0;
			saw_bang = 0;
			eol_seen = 0;
			open_pending = 0;
			rest_is_trailing = 0;
		endfunction

		function void take_byte(logic [7:0] b, logic eol);
			word_t             w;
			logic [KIND_W-1:0] kind;
			int unsigned       cur;
			bit                start, split;
			kind = KIND_NONE;
			cur = 0;
			start = 0;
			split = 0;
			if (eol_seen) clear_line();
			if (n_args > 0) cur = (n_args - 1) & 15;
			if (pos >= MSG_LEN - 1 || b == CH_NUL) phase = DISCARD;
			case (phase)
				AT_LINE_START: begin
					if (b == CH_COLON) begin
						saw_prefix = 1;
						open_pending = 1;
						phase = IN_PREFIX;
					end else if (b == CH_SPACE) begin
						phase = BEFORE_ARG;
					end else begin
						kind = KIND_COMMAND;
						start = 1;
						phase = IN_CMD;
					end
				end
				IN_PREFIX: begin
					if (b == CH_SPACE) begin
						open_pending = 0;
						phase = BEFORE_CMD;
					end else begin
						kind = KIND_PREFIX;
						start = open_pending;
						open_pending = 0;
						if (b == CH_BANG && !saw_bang) begin
							split = 1;
							saw_bang = 1;
						end
					end
				end
				BEFORE_CMD: begin
					if (b != CH_SPACE) begin
						kind = KIND_COMMAND;
						start = 1;
						phase = IN_CMD;
					end
				end
				IN_CMD: begin
					if (b == CH_SPACE) phase = BEFORE_ARG;
					else kind = KIND_COMMAND;
				end
				BEFORE_ARG: begin
					if (b != CH_SPACE) begin
						cur = n_args & 15;
						n_args++;
						if (b == CH_COLON) begin
							open_pending = 1;
							rest_is_trailing = 1;
							phase = IN_REST;
						end else begin
							kind = KIND_MIDDLE;
							start = 1;
							if (n_args >= MAX_ARGS) begin
								rest_is_trailing = 0;
								phase = IN_REST;
							end else begin
								phase = IN_ARG;
							end
						end
					end
				end
				IN_ARG: begin
					if (b == CH_SPACE) phase = BEFORE_ARG;
					else kind = KIND_MIDDLE;
				end
				IN_REST: begin
					kind = rest_is_trailing ? KIND_TRAILING : KIND_MIDDLE;
					start = open_pending;
					open_pending = 0;
				end
				default: ;
			endcase
			if (kind != KIND_MIDDLE && kind != KIND_TRAILING) cur = 0;
			if (pos < MSG_LEN - 1) pos++;
			if (eol) eol_seen = 1;
			w.res.out_byte = b;
			w.res.field_kind = kind;
			w.res.arg_index = cur[IDX_W-1:0];
			w.res.field_start = start;
			w.res.nick_split = split;
			w.res.had_prefix = saw_prefix;
			w.res.arg_total = n_args[ARG_W-1:0];
			w.last = eol;
			tags_due.push_back(w);
			words_in++;
		endfunction

		function void check_tag(logic [OUT_W-1:0] data, logic last);
			word_t want;
			res_t  got;
			bit    bad;
			words_out++;
			got = data[OUT_W-2:0];
			if (tags_due.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("%0t: unexpected word %h last %b", $time, data, last);
				end
				return;
			end
			want = tags_due.pop_front();
			kind_hits[want.res.field_kind]++;
			if (want.res.arg_total > top_args) top_args = want.res.arg_total;
			bad = (got.out_byte !== want.res.out_byte) ||
				(got.field_kind !== want.res.field_kind) ||
				(got.arg_index !== want.res.arg_index) ||
				(got.field_start !== want.res.field_start) ||
				(got.nick_split !== want.res.nick_split) ||
				(got.had_prefix !== want.res.had_prefix) ||
				(got.arg_total !== want.res.arg_total) ||
				(data[OUT_W-1] !== 1'b0) || (last !== want.last);
			if (bad) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("%0t: word %0d exp byte %h kind %0d arg %0d start %b split %b",
						$time, words_out, want.res.out_byte, want.res.field_kind,
						want.res.arg_index, want.res.field_start, want.res.nick_split);
					$display("    prefix %b args %0d last %b | got byte %h kind %0d arg %0d",
						want.res.had_prefix, want.res.arg_total, want.last,
						got.out_byte, got.field_kind, got.arg_index);
					$display("    start %b split %b prefix %b args %0d last %b pad %b",
						got.field_start, got.nick_split, got.had_prefix, got.arg_total,
						last, data[OUT_W-1]);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata  = '0;
	logic              s_tlast  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;

	tag_board board;
	int       burst_left = 0;
	int       lines_sent = 0;
	int       longest = 0;
	int       quiet = 0;
	bit       hold_req = 0;
	int       rx_cycle = 0;
	int       rx_mode = 0;
	int       hold_left = 0;

	irc_message_tokenizer_top #(
		.MSG_LEN (MSG_LEN),
		.MAX_ARGS(MAX_ARGS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_tag(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet == STALL_LIMIT) begin
				$display("watchdog: %0d cycles without a word moving", quiet);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// receiver: ready pattern re-picked at random from four modes, long hold on request
	initial begin
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= (rx_cycle % 5 != 0);
					default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic offer_byte(input logic [7:0] b, input logic eol);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata <= b;
		s_tlast <= eol;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.take_byte(b, eol);
		@(negedge clk);
	endtask

	task automatic send_bytes(input logic [7:0] bq[$]);
		foreach (bq[i]) offer_byte(bq[i], i == bq.size() - 1);
		lines_sent++;
		if (bq.size() > longest) longest = bq.size();
	endtask

	task automatic send_text(input string s);
		logic [7:0] bq[$];
		for (int i = 0; i < s.len(); i++) bq.push_back(s[i]);
		send_bytes(bq);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (board.tags_due.size() != 0);
	endtask

	function automatic logic [7:0] pick_char(int colon_pct, int bang_pct);
		int         r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < colon_pct) return CH_COLON;
		if (r < colon_pct + bang_pct) return CH_BANG;
		c = 8'($urandom_range(8'h22, 8'h7E));
		if (c == CH_COLON) c = 8'h5F;
		return c;
	endfunction

	function automatic void add_spaces(ref logic [7:0] bq[$]);
		int n;
		n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
		repeat (n) bq.push_back(CH_SPACE);
	endfunction

	// mostly well-formed lines, some broken, some pure noise
	function automatic void make_line(ref logic [7:0] bq[$]);
		int shape, n_args, at;
		bq.delete();
		shape = $urandom_range(0, 99);
		if (shape < 8) begin
			repeat ($urandom_range(1, 24)) bq.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 1) == 1) begin
			bq.push_back(CH_COLON);
			repeat ($urandom_range(0, 8)) bq.push_back(pick_char(5, 15));
			add_spaces(bq);
		end else if ($urandom_range(0, 19) == 0) begin
			bq.push_back(CH_SPACE);
		end
		repeat ($urandom_range(1, 6)) bq.push_back(pick_char(6, 3));
		n_args = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 5);
		for (int i = 0; i < n_args; i++) begin
			add_spaces(bq);
			if (i == n_args - 1 && $urandom_range(0, 2) == 0) begin
				bq.push_back(CH_COLON);
				repeat ($urandom_range(0, 10))
					bq.push_back(($urandom_range(0, 4) == 0) ? CH_SPACE : pick_char(10, 5));
			end else begin
				repeat ($urandom_range(1, 5)) bq.push_back(pick_char(4, 4));
			end
		end
		if ($urandom_range(0, 9) == 0) add_spaces(bq);
		if (shape < 14) begin
			at = $urandom_range(0, bq.size() - 1);
			case ($urandom_range(0, 3))
				0: bq[at] = CH_NUL;
				1: bq[at] = CH_COLON;
				2: bq[at] = CH_SPACE;
				default: bq[at] = 8'($urandom_range(0, 255));
			endcase
		end
	endfunction

	initial begin
		logic [7:0] bq[$];
		int         n_lines;
		board = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text(":a!b! X y :t u");
		send_text(":");
		send_text(" Z");
		send_text("C:D :");
		bq = {8'h51, CH_NUL, 8'h77};
		send_bytes(bq);
		bq = {8'hFF};
		send_bytes(bq);

		hold_req = 1;
		burst_left = 48;
		n_lines = 0;
		while (board.words_in < ITEMS) begin
			make_line(bq);
			if (n_lines == 15) begin
				while (bq.size() < MSG_LEN + 1)
					bq.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE : pick_char(3, 3));
			end
			if (n_lines == 45) begin
				hold_req = 1;
				burst_left = 48;
			end
			if (n_lines % 20 == 19) wait_drained();
			send_bytes(bq);
			n_lines++;
		end

		wait_drained();
		repeat (8) @(negedge clk);
		$display("covered %0d lines (longest %0d bytes), %0d words in, %0d out, max args %0d",
			lines_sent, longest, board.words_in, board.words_out, board.top_args);
		$display("tags seen: none %0d, prefix %0d, command %0d, middle %0d, trailing %0d",
			board.kind_hits[KIND_NONE], board.kind_hits[KIND_PREFIX],
			board.kind_hits[KIND_COMMAND], board.kind_hits[KIND_MIDDLE],
			board.kind_hits[KIND_TRAILING]);
		if (board.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
